// File: src/hcbp_pkg.sv
// Package for the prefix-code bit packer: constants, item codes and payload types.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps

package hcbp_pkg;

	// Field widths and table geometry.
	localparam int MAX_CODE_LEN = 32;
	localparam int BYTE_BITS    = 8;
	localparam int KIND_W       = 2;
	localparam int SYM_W        = 8;
	localparam int CODE_W       = 32;
	localparam int LEN_W        = 6;
	localparam int TABLE_DEPTH  = 1 << SYM_W;
	localparam int ENTRY_W      = CODE_W + LEN_W;

	// The bit accumulator holds up to seven leftover bits plus one whole code.
	localparam int ACC_W = MAX_CODE_LEN + BYTE_BITS - 1;
	localparam int CNT_W = $clog2(ACC_W + 1);

	// Queue between the front end and the back end.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] packed_byte;
		logic                 last;
	} out_item_t;

	// One job for the back end: an encode with its looked-up code, or a flush.
	typedef struct packed {
		logic              is_flush;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} q_entry_t;

	// Status of the back end, watched by the checks at the top level.
	typedef struct packed {
		logic [CNT_W-1:0] bit_count;
		logic             pop;
		logic             q_nonempty;
	} back_status_t;

endpackage

// File: src/huffman_code_bit_packer.sv
// Top level of the prefix-code bit packer: front end, job queue and back end.
// Depends on hcbp_pkg, hcbp_front, hcbp_queue and hcbp_back.
//
//   Channel   Signals                          Payload
//   sym       sym_valid / sym_stall (in)       hcbp_pkg::in_item_t
//   byte      byte_valid / byte_stall (out)    hcbp_pkg::out_item_t
//
// A symbol transfer is taken every cycle while the four-entry job queue has room.
// The table lookup is registered; a code's first byte then passes the job queue, the
// accumulator and the output register, while a flush byte skips the accumulator.
// The accumulator emits one byte per cycle while byte_stall is low, so a code holds the
// back end until its bytes drain; a flush with bits pending needs the output slot alone.
// Reset clears the queue and the accumulator; the code table is not cleared.
// A stalled byte channel fills the queue, which then raises sym_stall.
`timescale 1ns / 1ps

module huffman_code_bit_packer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sym_valid,
	output logic                 sym_stall,
	input  hcbp_pkg::in_item_t   sym_item,
	output logic                 byte_valid,
	input  logic                 byte_stall,
	output hcbp_pkg::out_item_t  byte_item
);
	import hcbp_pkg::*;

	logic                q_push;
	q_entry_t            q_push_entry;
	logic                q_pop;
	q_entry_t            q_head;
	logic                q_nonempty;
	logic [Q_LVL_W-1:0]  q_level;
	back_status_t        bk_status;

	hcbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym_valid  (sym_valid),
		.sym_stall  (sym_stall),
		.sym_item   (sym_item),
		.q_level    (q_level),
		.push       (q_push),
		.push_entry (q_push_entry)
	);

	hcbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.pop        (q_pop),
		.head       (q_head),
		.nonempty   (q_nonempty),
		.level      (q_level)
	);

	hcbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.head       (q_head),
		.pop        (q_pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.status     (bk_status)
	);

	// The credit check must keep the queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && !q_pop |-> q_level < Q_LVL_W'(Q_DEPTH))
		else $error("job queue overflow");

	// The back end pops only a present job.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.pop |-> bk_status.q_nonempty)
		else $error("job queue underflow");

	// The accumulator never holds more than seven leftover bits plus one code.
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.bit_count <= CNT_W'(ACC_W))
		else $error("bit accumulator count out of range");

	// When a last byte is first offered, the accumulator holds no more than one code's bits.
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_item.last && !$past(byte_valid && byte_item.last)
		|-> bk_status.bit_count < CNT_W'(MAX_CODE_LEN + 1))
		else $error("flush left bits in the accumulator");

endmodule

// File: src/hcbp_front.sv
// Front end of the packer: accepts items, owns the code table and classifies items.
// Depends on hcbp_pkg; feeds encode and flush jobs into hcbp_queue.
`timescale 1ns / 1ps

module hcbp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sym_valid,
	output logic                          sym_stall,
	input  hcbp_pkg::in_item_t            sym_item,
	input  logic [hcbp_pkg::Q_LVL_W-1:0]  q_level,
	output logic                          push,
	output hcbp_pkg::q_entry_t            push_entry
);
	import hcbp_pkg::*;

	logic                  accept;
	logic [Q_LVL_W:0]      committed;
	logic [LEN_W-1:0]      len_sat;
	logic [CODE_W-1:0]     code_mask;
	logic [ENTRY_W-1:0]    code_table [TABLE_DEPTH];
	logic [ENTRY_W-1:0]    entry_s1;
	logic [KIND_W-1:0]     kind_s1;
	logic                  valid_s1;

	// Stall when the queue plus the item in flight could not take one more.
	assign committed = {1'b0, q_level} + (Q_LVL_W + 1)'(valid_s1);
	assign sym_stall = committed >= (Q_LVL_W + 1)'(Q_DEPTH);
	assign accept    = sym_valid && !sym_stall;

	// Saturate the loaded length and drop code bits above it.
	always_comb begin
		len_sat = (sym_item.code_length > LEN_W'(MAX_CODE_LEN)) ?
			LEN_W'(MAX_CODE_LEN) : sym_item.code_length;
		if (len_sat >= LEN_W'(CODE_W)) begin
			code_mask = '1;
		end else begin
			code_mask = (CODE_W'(1) << len_sat) - CODE_W'(1);
		end
	end

	// Code table: written by a load transfer, read by every transfer.
	always_ff @(posedge clk) begin
		if (accept && sym_item.kind == KIND_LOAD) begin
			code_table[sym_item.symbol] <= {sym_item.code_bits & code_mask, len_sat};
		end
		if (accept) begin
			entry_s1 <= code_table[sym_item.symbol];
			kind_s1  <= sym_item.kind;
		end
	end

	// Stage valid for the looked-up item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Only encode and flush items become back-end jobs.
	always_comb begin
		push                = valid_s1 && (kind_s1 == KIND_ENCODE || kind_s1 == KIND_FLUSH);
		push_entry.is_flush = kind_s1 == KIND_FLUSH;
		push_entry.code     = entry_s1[ENTRY_W-1:LEN_W];
		push_entry.len      = entry_s1[LEN_W-1:0];
	end

endmodule

// File: src/hcbp_queue.sv
// Short job queue between the front end and the back end of the packer.
// Depends on hcbp_pkg for the entry type and depth.
`timescale 1ns / 1ps

module hcbp_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  hcbp_pkg::q_entry_t            push_entry,
	input  logic                          pop,
	output hcbp_pkg::q_entry_t            head,
	output logic                          nonempty,
	output logic [hcbp_pkg::Q_LVL_W-1:0]  level
);
	import hcbp_pkg::*;

	q_entry_t             slots_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_LVL_W-1:0]   level_q;

	assign head     = slots_q[rd_ptr_q];
	assign nonempty = level_q != '0;
	assign level    = level_q;

	// Entry storage; the front end never pushes into a full queue.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + Q_LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - Q_LVL_W'(1);
			end
		end
	end

endmodule

// File: src/hcbp_back.sv
// Back end of the packer: bit accumulator that appends codes and drains bytes.
// Depends on hcbp_pkg; takes jobs from hcbp_queue and drives the byte channel.
`timescale 1ns / 1ps

module hcbp_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_nonempty,
	input  hcbp_pkg::q_entry_t      head,
	output logic                    pop,
	output logic                    byte_valid,
	input  logic                    byte_stall,
	output hcbp_pkg::out_item_t     byte_item,
	output hcbp_pkg::back_status_t  status
);
	import hcbp_pkg::*;

	// Bits above bit_cnt_q in acc_q are always zero.
	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  bit_cnt_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              slot_free;
	logic              emit;
	logic              flush_emit;
	logic              can_take;
	logic [ACC_W-1:0]  rem_acc;
	logic [CNT_W-1:0]  rem_cnt;
	logic [ACC_W-1:0]  acc_n;
	logic [CNT_W-1:0]  cnt_n;

	// Emit a whole byte if one is ready, then merge the next job into what is left.
	always_comb begin
		slot_free = !out_valid_q || !byte_stall;
		emit      = slot_free && (bit_cnt_q >= CNT_W'(BYTE_BITS));
		rem_acc   = emit ? (acc_q >> BYTE_BITS) : acc_q;
		rem_cnt   = emit ? (bit_cnt_q - CNT_W'(BYTE_BITS)) : bit_cnt_q;
		can_take  = rem_cnt < CNT_W'(BYTE_BITS);
		pop       = 1'b0;
		flush_emit = 1'b0;
		acc_n     = rem_acc;
		cnt_n     = rem_cnt;
		if (q_nonempty && can_take) begin
			if (head.is_flush) begin
				// A flush with bits pending needs the output slot to itself.
				if (rem_cnt == '0) begin
					pop = 1'b1;
				end else if (!emit && slot_free) begin
					pop        = 1'b1;
					flush_emit = 1'b1;
				end
				if (pop) begin
					acc_n = '0;
					cnt_n = '0;
				end
			end else begin
				pop   = 1'b1;
				acc_n = rem_acc | (ACC_W'(head.code) << rem_cnt[$clog2(BYTE_BITS)-1:0]);
				cnt_n = rem_cnt + CNT_W'(head.len);
			end
		end
	end

	// Accumulator and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			acc_q     <= acc_n;
			bit_cnt_q <= cnt_n;
			if (emit || flush_emit) begin
				out_valid_q <= 1'b1;
			end else if (!byte_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload; the remaining flush bits are already zero-padded.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.packed_byte <= acc_q[BYTE_BITS-1:0];
			out_q.last        <= 1'b0;
		end else if (flush_emit) begin
			out_q.packed_byte <= rem_acc[BYTE_BITS-1:0];
			out_q.last        <= 1'b1;
		end
	end

	assign byte_valid        = out_valid_q;
	assign byte_item         = out_q;
	assign status.bit_count  = bit_cnt_q;
	assign status.pop        = pop;
	assign status.q_nonempty = q_nonempty;

endmodule

// File: test/hcbp_byte_checker.sv
// Checker for the prefix-code bit packer: watches both channels and predicts every byte.
// Depends on hcbp_pkg for the payload types, item kinds and field widths.
`timescale 1ns / 1ps

module hcbp_byte_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sym_valid,
	input  logic                 sym_stall,
	input  hcbp_pkg::in_item_t   sym_item,
	input  logic                 byte_valid,
	input  logic                 byte_stall,
	input  hcbp_pkg::out_item_t  byte_item,
	output int                   mismatches,
	output int                   bytes_owed
);
	import hcbp_pkg::*;

	// Shadow code table; entries hold only the bits inside their stored length.
	logic [CODE_W-1:0] code_word_tab [TABLE_DEPTH];
	logic [LEN_W-1:0]  code_len_tab  [TABLE_DEPTH];

	// Leftover stream bits that have not yet filled a byte.
	logic [6:0]        carry_bits;
	int                carry_count;

	// Bytes predicted but not yet seen on the byte channel, oldest first.
	out_item_t         owed_q [$];

	logic [63:0]       stream_acc;
	int                stream_count;
	logic [LEN_W-1:0]  stored_len;
	out_item_t         want;

	task automatic report_mismatch(input string msg);
		$display("[%0t] checker: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q.delete();
			carry_bits = '0;
			carry_count = 0;
			mismatches = 0;
			bytes_owed = 0;
		end else begin
			// Compare each byte transfer with the oldest predicted byte.
			if (byte_valid && !byte_stall) begin
				if (owed_q.size() == 0) begin
					report_mismatch($sformatf("unexpected byte 0x%0h last=%0b",
						byte_item.packed_byte, byte_item.last));
				end else begin
					want = owed_q.pop_front();
					if (byte_item.packed_byte !== want.packed_byte)
						report_mismatch($sformatf("packed_byte got 0x%0h, expected 0x%0h",
							byte_item.packed_byte, want.packed_byte));
					if (byte_item.last !== want.last)
						report_mismatch($sformatf("last got %0b, expected %0b",
							byte_item.last, want.last));
				end
			end

			// Advance the prediction for each symbol transfer.
			if (sym_valid && !sym_stall) begin
				case (sym_item.kind)
					KIND_LOAD: begin
						// Lengths above the maximum saturate; bits past the length drop.
						stored_len = (sym_item.code_length > MAX_CODE_LEN) ?
							LEN_W'(MAX_CODE_LEN) : sym_item.code_length;
						code_len_tab[sym_item.symbol] = stored_len;
						code_word_tab[sym_item.symbol] = sym_item.code_bits &
							CODE_W'((64'd1 << stored_len) - 64'd1);
					end
					KIND_ENCODE: begin
						// Append the code after the leftover bits and peel off whole bytes.
						stream_acc = 64'(carry_bits) |
							(64'(code_word_tab[sym_item.symbol]) << carry_count);
						stream_count = carry_count + code_len_tab[sym_item.symbol];
						while (stream_count >= BYTE_BITS) begin
							want.packed_byte = stream_acc[7:0];
							want.last = 1'b0;
							owed_q.push_back(want);
							stream_acc = stream_acc >> BYTE_BITS;
							stream_count -= BYTE_BITS;
						end
						carry_bits = stream_acc[6:0];
						carry_count = stream_count;
					end
					KIND_FLUSH: begin
						// A flush makes a padded final byte only when bits are left over.
						if (carry_count != 0) begin
							want.packed_byte = {1'b0, carry_bits};
							want.last = 1'b1;
							owed_q.push_back(want);
						end
						carry_bits = '0;
						carry_count = 0;
					end
					default: begin
						// The unused kind leaves all state alone.
					end
				endcase
			end
			bytes_owed = owed_q.size();
		end
	end

endmodule

// File: test/tb_top.sv
// Testbench top for the prefix-code bit packer: clock, reset, symbol stimulus and byte stalls.
// Depends on hcbp_pkg, huffman_code_bit_packer and hcbp_byte_checker.
`timescale 1ns / 1ps

module tb_top;
	import hcbp_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS  = 160;
	localparam int FLOOD_ITEMS   = 24;
	localparam int HOLD_CYCLES   = 80;
	localparam int DRAIN_CYCLES  = 16;
	localparam int QUIET_LIMIT   = 1000;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

	logic        clk;
	logic        arst_n;
	logic        sym_valid;
	logic        sym_stall;
	in_item_t    sym_item;
	logic        byte_valid;
	logic        byte_stall;
	out_item_t   byte_item;
	int          mismatch_count;
	int          bytes_owed;

	// Sender burst state, receiver hold-off and stall pattern.
	int          burst_left;
	int          hold_left;
	int          phase_left;
	int          stall_tick;
	stall_mode_t stall_mode;
	int          quiet_cycles;

	// Symbols whose table entry has been written; only these are encoded.
	bit          is_loaded [TABLE_DEPTH];
	logic [7:0]  loaded_syms [$];

	huffman_code_bit_packer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym_valid  (sym_valid),
		.sym_stall  (sym_stall),
		.sym_item   (sym_item),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item)
	);

	hcbp_byte_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym_valid  (sym_valid),
		.sym_stall  (sym_stall),
		.sym_item   (sym_item),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.mismatches (mismatch_count),
		.bytes_owed (bytes_owed)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic in_item_t make_item(input logic [KIND_W-1:0] kind,
			input logic [SYM_W-1:0] symbol, input logic [CODE_W-1:0] code,
			input logic [LEN_W-1:0] len);
		in_item_t it;
		it.kind = kind;
		it.symbol = symbol;
		it.code_bits = code;
		it.code_length = len;
		return it;
	endfunction

	// Offer one item and hold it until the transfer; bursts are separated by random gaps.
	task automatic push_symbol_item(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 50) :
				$urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				sym_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		sym_valid <= 1'b1;
		sym_item <= it;
		@(posedge clk);
		while (sym_stall) @(posedge clk);
		burst_left--;
	endtask

	task automatic load_code(input logic [7:0] sym, input logic [CODE_W-1:0] code,
			input logic [LEN_W-1:0] len);
		push_symbol_item(make_item(KIND_LOAD, sym, code, len));
		if (!is_loaded[sym]) begin
			is_loaded[sym] = 1'b1;
			loaded_syms.push_back(sym);
		end
	endtask

	task automatic encode_symbol(input logic [7:0] sym);
		push_symbol_item(make_item(KIND_ENCODE, sym, $urandom, 6'($urandom)));
	endtask

	task automatic flush_stream();
		push_symbol_item(make_item(KIND_FLUSH, 8'($urandom), $urandom, 6'($urandom)));
	endtask

	// Stall the byte side for a long stretch while feeding four-byte codes back to back.
	task automatic hold_output_and_flood();
		load_code(8'd255, $urandom, 6'd32);
		hold_left = HOLD_CYCLES;
		burst_left = FLOOD_ITEMS + 2;
		repeat (FLOOD_ITEMS) encode_symbol(8'd255);
	endtask

	// Byte receiver: a long hold when asked, else a stall pattern that changes by phase.
	always @(negedge clk) begin
		stall_tick++;
		if (hold_left > 0) begin
			byte_stall <= 1'b1;
			hold_left--;
		end else begin
			if (phase_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				phase_left = $urandom_range(8, 60);
			end
			phase_left--;
			case (stall_mode)
				STALL_NONE:     byte_stall <= 1'b0;
				STALL_LIGHT:    byte_stall <= ($urandom_range(0, 99) < 30);
				STALL_PERIODIC: byte_stall <= (stall_tick % 3 == 0);
				default:        byte_stall <= ($urandom_range(0, 99) < 70);
			endcase
		end
	end

	// Watchdog: ends the run when neither channel has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (sym_valid && !sym_stall) || (byte_valid && !byte_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("huffman_code_bit_packer regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned pick;
		int unsigned load_pct;
		logic [7:0]  sym;
		logic [5:0]  len;

		arst_n = 1'b0;
		sym_valid = 1'b0;
		sym_item = '0;
		byte_stall = 1'b0;
		burst_left = 0;
		hold_left = 0;
		phase_left = 0;
		stall_tick = 0;
		stall_mode = STALL_NONE;
		quiet_cycles = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part: zero, full and overlong lengths, stray high code bits,
		// flush with nothing pending, back-to-back flushes and the unused kind.
		load_code(8'd0, 32'h0000_0000, 6'd0);
		load_code(8'd255, 32'hFFFF_FFFF, 6'd32);
		load_code(8'd1, 32'hA5A5_5A5A, 6'd63);
		load_code(8'd2, 32'hFFFF_FFFF, 6'd1);
		load_code(8'd3, 32'h0000_0005, 6'd3);
		load_code(8'd128, 32'hDEAD_BEEF, 6'd33);
		flush_stream();
		encode_symbol(8'd0);
		encode_symbol(8'd255);
		encode_symbol(8'd2);
		encode_symbol(8'd255);
		encode_symbol(8'd1);
		encode_symbol(8'd3);
		flush_stream();
		flush_stream();
		push_symbol_item(make_item(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
		encode_symbol(8'd3);
		encode_symbol(8'd3);
		encode_symbol(8'd3);
		encode_symbol(8'd128);
		flush_stream();

		// Random part: mostly encodes of loaded symbols, with loads, flushes and noise.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 40 || n == 120)
				hold_output_and_flood();
			pick = $urandom_range(0, 99);
			load_pct = (loaded_syms.size() < 24) ? 40 : 10;
			if (pick < load_pct) begin
				pick = $urandom_range(0, 99);
				if (pick < 5)
					len = 6'd0;
				else if (pick < 75)
					len = 6'($urandom_range(1, 10));
				else if (pick < 92)
					len = 6'($urandom_range(11, 32));
				else
					len = 6'($urandom_range(33, 63));
				load_code(8'($urandom), $urandom, len);
			end else if (pick < 88) begin
				sym = 8'($urandom);
				if (!is_loaded[sym])
					sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
				encode_symbol(sym);
			end else if (pick < 96) begin
				flush_stream();
			end else begin
				push_symbol_item(make_item(KIND_UNUSED, 8'($urandom), $urandom,
					6'($urandom)));
			end
		end
		flush_stream();

		// Wait for every predicted byte, then give stray bytes time to show up.
		@(negedge clk);
		sym_valid <= 1'b0;
		while (bytes_owed != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("huffman_code_bit_packer regression: pass");
		else
			$display("huffman_code_bit_packer regression: fail");
		$finish;
	end

endmodule
